FILE: design/frpm_pkg.sv
// Shared widths, register indexes, reset values and action codes of the frame rate phase mapper.
package frpm_pkg;

    localparam int FRAME_W    = 31;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 32;
    localparam int OFF_W      = 7;
    localparam int SRC_W      = 31;
    localparam int PHASE_W    = 9;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = FRAME_W + NUM_W;

    localparam int PHASE_STEPS_DEF = 256;

    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_RATE_NUM      = 2'd0;
    localparam t_cfg_idx CFG_RATE_DEN      = 2'd1;
    localparam t_cfg_idx CFG_REF_OFFSET    = 2'd2;
    localparam t_cfg_idx CFG_SOURCE_FRAMES = 2'd3;

    localparam logic [NUM_W-1:0] RATE_NUM_RST      = 32'd1;
    localparam logic [DEN_W-1:0] RATE_DEN_RST      = 32'd2;
    localparam logic [OFF_W-1:0] REF_OFFSET_RST    = 7'd1;
    localparam logic [SRC_W-1:0] SOURCE_FRAMES_RST = 31'd1;

    localparam t_action ACT_COPY_LEFT  = 2'd0;
    localparam t_action ACT_COPY_RIGHT = 2'd1;
    localparam t_action ACT_INTERP     = 2'd2;
    localparam t_action ACT_PAST_END   = 2'd3;

endpackage

FILE: design/frame_rate_phase_mapper_unit.sv
// Frame rate phase mapper: source frame pair, temporal phase and action per output frame.
// Stages in order: one multiply stage, 63 cells for the frame quotient, one scaling stage,
// the phase cells, the offset-division cells and the output register.
// Throughput: one request per cycle while i_out_ready does not stall the output; every cell
// stage holds its own request and advances into a free or draining neighbor. Synchronous
// active-low reset empties the pipeline and loads the register defaults (num 1, den 2,
// offset 1, source frames 1).
module frame_rate_phase_mapper_unit #(
    parameter int PHASE_STEPS = frpm_pkg::PHASE_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [frpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [frpm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [frpm_pkg::FRAME_W-1:0]    i_out_frame,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [frpm_pkg::SRC_W-1:0]      o_left_index,
    output logic [frpm_pkg::SRC_W-1:0]      o_right_index,
    output logic [frpm_pkg::PHASE_W-1:0]    o_phase,
    output logic [frpm_pkg::ACTION_W-1:0]   o_action
);
    import frpm_pkg::*;

    localparam int Q2_W   = $clog2(2 * PHASE_STEPS);
    localparam int PH_W   = $clog2(PHASE_STEPS + 1);
    localparam int DVD2_W = DEN_W + Q2_W;
    localparam int C1_N   = PROD_W;
    localparam int C2_N   = Q2_W;
    localparam int C3_N   = PH_W;

    // ---------------- configuration registers ----------------
    logic [NUM_W-1:0] r_rate_num;
    logic [DEN_W-1:0] r_rate_den;
    logic [OFF_W-1:0] r_ref_offset;
    logic [SRC_W-1:0] r_source_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_num      <= RATE_NUM_RST;
            r_rate_den      <= RATE_DEN_RST;
            r_ref_offset    <= REF_OFFSET_RST;
            r_source_frames <= SOURCE_FRAMES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RATE_NUM:      r_rate_num      <= i_cfg_wdata[NUM_W-1:0];
                CFG_RATE_DEN:      r_rate_den      <= i_cfg_wdata[DEN_W-1:0];
                CFG_REF_OFFSET:    r_ref_offset    <= i_cfg_wdata[OFF_W-1:0];
                CFG_SOURCE_FRAMES: r_source_frames <= i_cfg_wdata[SRC_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DEN_W-1:0] w_den;
    logic [OFF_W-1:0] w_off_div;

    // zero denominator acts as one; offsets of 0 and 1 leave the phase undivided
    assign w_den     = (r_rate_den == '0) ? DEN_W'(1) : r_rate_den;
    assign w_off_div = (r_ref_offset > OFF_W'(1)) ? r_ref_offset : OFF_W'(1);

    // ---------------- multiply stage ----------------
    logic              r_m_valid;
    logic [PROD_W-1:0] r_m_prod;
    logic [PROD_W-1:0] n_m_prod;
    logic              w_m_ready;

    assign n_m_prod   = PROD_W'(i_out_frame) * PROD_W'(r_rate_num);
    assign o_in_ready = !r_m_valid || w_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_m_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_m_prod <= n_m_prod;
        end
    end

    // ---------------- frame quotient cells: prod / den ----------------
    logic              c1_v   [0:C1_N];
    logic              c1_r   [0:C1_N];
    logic [DEN_W-1:0]  c1_rem [0:C1_N];
    logic [PROD_W-1:0] c1_dq  [0:C1_N];
    logic              c1_sd  [0:C1_N];

    assign c1_v[0]   = r_m_valid;
    assign w_m_ready = c1_r[0];
    assign c1_rem[0] = '0;
    assign c1_dq[0]  = r_m_prod;
    assign c1_sd[0]  = 1'b0;

    for (genvar k = 0; k < C1_N; k++) begin : g_c1
        frpm_div_cell #(
            .DIV_W  (DEN_W),
            .DQ_W   (PROD_W),
            .SIDE_W (1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c1_v[k]),
            .o_ready (c1_r[k]),
            .i_den   (w_den),
            .i_rem   (c1_rem[k]),
            .i_dq    (c1_dq[k]),
            .i_side  (c1_sd[k]),
            .o_valid (c1_v[k+1]),
            .i_ready (c1_r[k+1]),
            .o_rem   (c1_rem[k+1]),
            .o_dq    (c1_dq[k+1]),
            .o_side  (c1_sd[k+1])
        );
    end

    // ---------------- scaling stage: rem * 2 * PHASE_STEPS ----------------
    logic              r_s_valid;
    logic [PROD_W-1:0] r_s_left;
    logic [DVD2_W-1:0] r_s_dvd;
    logic [DVD2_W-1:0] n_s_dvd;
    logic              w_s_ready;
    logic              w_s_open;

    assign n_s_dvd      = DVD2_W'(c1_rem[C1_N]) * DVD2_W'(2 * PHASE_STEPS);
    assign w_s_open     = !r_s_valid || w_s_ready;
    assign c1_r[C1_N]   = w_s_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_s_open) begin
            r_s_valid <= c1_v[C1_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c1_v[C1_N] && w_s_open) begin
            r_s_left <= c1_dq[C1_N];
            r_s_dvd  <= n_s_dvd;
        end
    end

    // ---------------- phase cells: floor(2*S*rem / den) ----------------
    logic              c2_v   [0:C2_N];
    logic              c2_r   [0:C2_N];
    logic [DEN_W-1:0]  c2_rem [0:C2_N];
    logic [Q2_W-1:0]   c2_dq  [0:C2_N];
    logic [PROD_W-1:0] c2_sd  [0:C2_N];

    // top part is already below den since the dividend is under den << Q2_W
    assign c2_v[0]   = r_s_valid;
    assign w_s_ready = c2_r[0];
    assign c2_rem[0] = r_s_dvd[DVD2_W-1:Q2_W];
    assign c2_dq[0]  = r_s_dvd[Q2_W-1:0];
    assign c2_sd[0]  = r_s_left;

    for (genvar k = 0; k < C2_N; k++) begin : g_c2
        frpm_div_cell #(
            .DIV_W  (DEN_W),
            .DQ_W   (Q2_W),
            .SIDE_W (PROD_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c2_v[k]),
            .o_ready (c2_r[k]),
            .i_den   (w_den),
            .i_rem   (c2_rem[k]),
            .i_dq    (c2_dq[k]),
            .i_side  (c2_sd[k]),
            .o_valid (c2_v[k+1]),
            .i_ready (c2_r[k+1]),
            .o_rem   (c2_rem[k+1]),
            .o_dq    (c2_dq[k+1]),
            .o_side  (c2_sd[k+1])
        );
    end

    // half-up rounding: floor((q2 + 1) / 2)
    logic [Q2_W:0]   w_q2_inc;
    logic [PH_W-1:0] w_phase_raw;

    assign w_q2_inc    = {1'b0, c2_dq[C2_N]} + (Q2_W + 1)'(1);
    assign w_phase_raw = PH_W'(w_q2_inc >> 1);

    // ---------------- offset division cells: phase / offset ----------------
    logic              c3_v   [0:C3_N];
    logic              c3_r   [0:C3_N];
    logic [OFF_W-1:0]  c3_rem [0:C3_N];
    logic [PH_W-1:0]   c3_dq  [0:C3_N];
    logic [PROD_W-1:0] c3_sd  [0:C3_N];

    assign c3_v[0]    = c2_v[C2_N];
    assign c2_r[C2_N] = c3_r[0];
    assign c3_rem[0]  = '0;
    assign c3_dq[0]   = w_phase_raw;
    assign c3_sd[0]   = c2_sd[C2_N];

    for (genvar k = 0; k < C3_N; k++) begin : g_c3
        frpm_div_cell #(
            .DIV_W  (OFF_W),
            .DQ_W   (PH_W),
            .SIDE_W (PROD_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c3_v[k]),
            .o_ready (c3_r[k]),
            .i_den   (w_off_div),
            .i_rem   (c3_rem[k]),
            .i_dq    (c3_dq[k]),
            .i_side  (c3_sd[k]),
            .o_valid (c3_v[k+1]),
            .i_ready (c3_r[k+1]),
            .o_rem   (c3_rem[k+1]),
            .o_dq    (c3_dq[k+1]),
            .o_side  (c3_sd[k+1])
        );
    end

    // ---------------- clamp, action and output register ----------------
    logic [PROD_W-1:0] w_left;
    logic [PROD_W:0]   w_right;
    logic [PH_W-1:0]   w_phase;
    logic [SRC_W-1:0]  w_last;
    logic [SRC_W-1:0]  w_left_cl;
    logic [SRC_W-1:0]  w_right_cl;
    t_action           w_action;
    logic              w_o_open;

    assign w_left  = c3_sd[C3_N];
    assign w_phase = c3_dq[C3_N];
    assign w_right = {1'b0, w_left} + (PROD_W + 1)'(r_ref_offset);
    assign w_last  = (r_source_frames == '0) ? '0 : r_source_frames - SRC_W'(1);

    assign w_left_cl  = (w_left < PROD_W'(w_last)) ? w_left[SRC_W-1:0] : w_last;
    assign w_right_cl = (w_right < (PROD_W + 1)'(w_last)) ? w_right[SRC_W-1:0] : w_last;

    always_comb begin
        if (w_phase == '0) begin
            w_action = ACT_COPY_LEFT;
        end else if (w_phase == PH_W'(PHASE_STEPS)) begin
            w_action = ACT_COPY_RIGHT;
        end else if ((w_left < PROD_W'(r_source_frames)) &&
                     (w_right < (PROD_W + 1)'(r_source_frames))) begin
            w_action = ACT_INTERP;
        end else begin
            w_action = ACT_PAST_END;
        end
    end

    logic             r_o_valid;
    logic [SRC_W-1:0] r_o_left;
    logic [SRC_W-1:0] r_o_right;
    logic [PHASE_W-1:0] r_o_phase;
    t_action          r_o_action;

    assign w_o_open   = !r_o_valid || i_out_ready;
    assign c3_r[C3_N] = w_o_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_open) begin
            r_o_valid <= c3_v[C3_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c3_v[C3_N] && w_o_open) begin
            r_o_left   <= w_left_cl;
            r_o_right  <= w_right_cl;
            r_o_phase  <= PHASE_W'(w_phase);
            r_o_action <= w_action;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_left_index  = r_o_left;
    assign o_right_index = r_o_right;
    assign o_phase       = r_o_phase;
    assign o_action      = r_o_action;

`ifndef SYNTHESIS
    // frame quotient remainder must stay below the divisor
    a_c1_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c1_v[C1_N] |-> (c1_rem[C1_N] < w_den))
        else $error("frame quotient remainder not below denominator");

    // divided phase never exceeds the full step count
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c3_v[C3_N] |-> (w_phase <= PH_W'(PHASE_STEPS)))
        else $error("phase above step count");

    // a stalled multiply stage keeps its product
    a_mul_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !w_m_ready) |=> (r_m_valid && $stable(r_m_prod)))
        else $error("multiply stage lost a stalled request");

    // clamping keeps the pair ordered
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_index <= o_right_index))
        else $error("right index below left index");
`endif

endmodule

FILE: design/frpm_div_cell.sv
// One restoring-division cell: produces one quotient bit per request and hands it on.
module frpm_div_cell #(
    parameter int DIV_W  = 32,
    parameter int DQ_W   = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DIV_W-1:0]  i_den,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [DQ_W-1:0]   i_dq,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DIV_W-1:0]  o_rem,
    output logic [DQ_W-1:0]   o_dq,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [DIV_W-1:0]  r_rem;
    logic [DQ_W-1:0]   r_dq;
    logic [SIDE_W-1:0] r_side;

    logic [DIV_W-1:0]  n_rem;
    logic [DQ_W-1:0]   n_dq;
    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;
    logic              w_load;

    // dq holds the dividend bits still to come in its top and the quotient bits in its bottom
    always_comb begin
        w_trial = {i_rem, i_dq[DQ_W-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
        n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        n_dq    = {i_dq[DQ_W-2:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem  <= n_rem;
            r_dq   <= n_dq;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_side  = r_side;

endmodule

FILE: test/testbench.sv
// Testbench for the frame rate phase mapper: predicted frame pairs, phases and actions vs. the unit.
`timescale 1ns / 1ps

module testbench;
    import frpm_pkg::*;

    localparam int STEPS           = PHASE_STEPS_DEF;
    localparam int CLK_HALF        = 4;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RANDOM_PHASES   = 11;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int BURST_PHASES    = 2;
    localparam int BURST_ITEMS     = 55;

    typedef struct packed {
        logic [SRC_W-1:0]   left;
        logic [SRC_W-1:0]   right;
        logic [PHASE_W-1:0] phase;
        t_action            action;
    } t_frame_map;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [FRAME_W-1:0]    i_out_frame;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [SRC_W-1:0]      o_left_index;
    logic [SRC_W-1:0]      o_right_index;
    logic [PHASE_W-1:0]    o_phase;
    logic [ACTION_W-1:0]   o_action;

    // shadow copies of the rate registers
    logic [NUM_W-1:0] num_q;
    logic [DEN_W-1:0] den_q;
    logic [OFF_W-1:0] offset_q;
    logic [SRC_W-1:0] frames_q;

    t_frame_map pending_maps[$];
    int         mismatch_count = 0;
    int         gap_pct = 25;
    bit         full_rate = 1'b0;

    frame_rate_phase_mapper_unit #(
        .PHASE_STEPS(STEPS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_out_frame  (i_out_frame),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_left_index (o_left_index),
        .o_right_index(o_right_index),
        .o_phase      (o_phase),
        .o_action     (o_action)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_frame_map predict_frame_map(input logic [FRAME_W-1:0] n);
        logic [63:0] den;
        logic [63:0] prod;
        logic [63:0] left;
        logic [63:0] rem;
        logic [63:0] right;
        logic [63:0] frames;
        logic [63:0] last;
        logic [63:0] ph;
        logic [63:0] left_c;
        logic [63:0] right_c;
        t_frame_map  m;
        frames = 64'(frames_q);
        den    = (den_q == '0) ? 64'd1 : 64'(den_q);
        prod   = 64'(n) * 64'(num_q);
        left   = prod / den;
        rem    = prod % den;
        right  = left + 64'(offset_q);
        last   = (frames == 64'd0) ? 64'd0 : frames - 64'd1;
        // round half up: (2*rem*steps + den) / (2*den)
        ph = ((rem << 1) * 64'(STEPS) + den) / (den << 1);
        if (offset_q > 1)
            ph = ph / 64'(offset_q);
        if (ph == 64'd0)
            m.action = ACT_COPY_LEFT;
        else if (ph == 64'(STEPS))
            m.action = ACT_COPY_RIGHT;
        else if (left < frames && right < frames)
            m.action = ACT_INTERP;
        else
            m.action = ACT_PAST_END;
        left_c  = (left < last) ? left : last;
        right_c = (right < last) ? right : last;
        m.left  = left_c[SRC_W-1:0];
        m.right = right_c[SRC_W-1:0];
        m.phase = ph[PHASE_W-1:0];
        return m;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_frame_map want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_maps.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: left %0d right %0d phase %0d action %0d",
                         $time, o_left_index, o_right_index, o_phase, o_action);
            end else begin
                want = pending_maps.pop_front();
                if (o_left_index !== want.left || o_right_index !== want.right ||
                    o_phase !== want.phase || o_action !== want.action) begin
                    mismatch_count++;
                    $display("%0t: expected l %0d r %0d ph %0d act %0d, got l %0d r %0d ph %0d act %0d",
                             $time, want.left, want.right, want.phase, want.action,
                             o_left_index, o_right_index, o_phase, o_action);
                end
            end
        end
    end

    // downstream stalls in bursts; none once full_rate is set
    initial begin
        i_out_ready = 1'b0;
        forever begin
            if (!full_rate && $urandom_range(0, 4) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    task automatic send_frame(input logic [FRAME_W-1:0] n);
        @(negedge i_clk);
        if (!full_rate && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_out_frame = n;
        do @(posedge i_clk); while (!o_in_ready);
        pending_maps.push_back(predict_frame_map(n));
    endtask

    task automatic drain_requests;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        case (idx)
            CFG_RATE_NUM:      num_q    = data;
            CFG_RATE_DEN:      den_q    = data;
            CFG_REF_OFFSET:    offset_q = data[OFF_W-1:0];
            CFG_SOURCE_FRAMES: frames_q = data[SRC_W-1:0];
            default: ;
        endcase
    endtask

    // registers change only with the pipeline empty
    task automatic load_rates(input logic [31:0] num, input logic [31:0] den,
                              input logic [31:0] off_word, input logic [31:0] frames_word);
        drain_requests();
        write_reg(CFG_RATE_NUM, num);
        write_reg(CFG_RATE_DEN, den);
        write_reg(CFG_REF_OFFSET, off_word);
        write_reg(CFG_SOURCE_FRAMES, frames_word);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic pick_random_rates;
        logic [31:0] num;
        logic [31:0] den;
        logic [6:0]  off;
        logic [30:0] src;
        logic [31:0] noise;
        case ($urandom_range(0, 3))
            0:       num = $urandom_range(1, 16);
            1:       num = $urandom;
            2:       num = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 1));
            default: num = $urandom_range(1, 1000);
        endcase
        case ($urandom_range(0, 3))
            0:       den = $urandom_range(1, 16);
            1:       den = $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0:       den = 32'd0;
                    1:       den = 32'd1;
                    2:       den = 32'hFFFF_FFFF;
                    default: den = 32'd512;
                endcase
            end
            default: den = $urandom_range(1, 1000);
        endcase
        case ($urandom_range(0, 3))
            0:       off = 7'($urandom_range(0, 2));
            1, 2:    off = 7'($urandom_range(0, 64));
            default: off = 7'($urandom_range(65, 127));
        endcase
        case ($urandom_range(0, 3))
            0:       src = 31'($urandom_range(0, 16));
            1:       src = 31'($urandom_range(1, 1000000));
            2:       src = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            default: src = 31'($urandom);
        endcase
        noise = $urandom;
        // unused upper bits of the write data carry noise
        load_rates(num, den, {noise[31:7], off}, {noise[0], src});
    endtask

    function automatic logic [FRAME_W-1:0] rand_frame();
        logic [31:0] r;
        case ($urandom_range(0, 4))
            0:       r = $urandom_range(0, 255);
            1:       r = $urandom_range(0, 65535);
            2, 3:    r = $urandom;
            default: r = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0;
        endcase
        return r[FRAME_W-1:0];
    endfunction

    task automatic test_reset_defaults;
        send_frame(31'd0);
        send_frame(31'd1);
        send_frame(31'd2);
        send_frame(31'd3);
        send_frame(31'h7FFF_FFFF);
    endtask

    task automatic test_directed_cases;
        // huge quotient, clamped to the last frame
        load_rates(32'hFFFF_FFFF, 32'd1, 32'd64, 32'hFFFF_FFFF);
        send_frame(31'h7FFF_FFFF);
        send_frame(31'd1);
        // zero denominator, zero offset, empty clip
        load_rates(32'd3, 32'd0, 32'd0, 32'd0);
        send_frame(31'd7);
        load_rates(32'd1, 32'd3, 32'd0, 32'd0);
        send_frame(31'd1);
        // zero numerator
        load_rates(32'd0, 32'd7, 32'd3, 32'd100);
        send_frame(31'h7FFF_FFFF);
        // phase rounds up to a full step: copy right
        load_rates(32'd1023, 32'd1024, 32'd1, 32'd100);
        send_frame(31'd1);
        send_frame(31'd2);
        load_rates(32'd1023, 32'd1024, 32'd0, 32'd100);
        send_frame(31'd1);
        // offset division, including an offset beyond 64
        load_rates(32'd1, 32'd3, 32'd2, 32'd1000);
        send_frame(31'd7);
        send_frame(31'd8);
        load_rates(32'd1, 32'd3, 32'hFFFF_FFFF, 32'd1000);
        send_frame(31'd8);
        send_frame(31'd7);
        // exact half rounds up, quarter rounds down
        load_rates(32'd1, 32'd512, 32'd1, 32'hFFFF_FFFF);
        send_frame(31'd1);
        send_frame(31'd511);
        send_frame(31'd513);
        load_rates(32'd1, 32'd1024, 32'd1, 32'hFFFF_FFFF);
        send_frame(31'd1);
    endtask

    task automatic test_random_rates;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            gap_pct = $urandom_range(0, 40);
            pick_random_rates();
            repeat (ITEMS_PER_PHASE) send_frame(rand_frame());
        end
    endtask

    task automatic test_full_throughput;
        full_rate = 1'b1;
        for (int p = 0; p < BURST_PHASES; p++) begin
            pick_random_rates();
            repeat (BURST_ITEMS) send_frame(rand_frame());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_RATE_NUM;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_out_frame = '0;
        num_q       = RATE_NUM_RST;
        den_q       = RATE_DEN_RST;
        offset_q    = REF_OFFSET_RST;
        frames_q    = SOURCE_FRAMES_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_random_rates();
        test_full_throughput();

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_maps.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
